FILE: rtl/core/tcad_pkg.sv
// Shared types and constants for the tap changer auto decision block.
// No dependencies.
package tcad_pkg;

    typedef struct packed {
        logic               req_type;
        logic        [15:0] volt_a;
        logic        [15:0] volt_b;
        logic        [15:0] volt_c;
        logic signed [15:0] real_a;
        logic signed [15:0] reactive_a;
        logic signed [15:0] real_b;
        logic signed [15:0] reactive_b;
        logic signed [15:0] real_c;
        logic signed [15:0] reactive_c;
        logic        [1:0]  gear_setting;
        logic               large_capacity_now;
    } in_item_t;

    typedef struct packed {
        logic [1:0] motion;
        logic       raise_request;
        logic       lower_request;
        logic       capacity_request;
    } out_item_t;

    localparam int unsigned CFG_W     = 34;
    localparam int unsigned CFG_IDX_W = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAISE_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOCK_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_THR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CUR_RATIO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_DELAY = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAP_DELAY  = 3'd7;

    // motion codes
    localparam logic [1:0] MOTION_NONE  = 2'd0;
    localparam logic [1:0] MOTION_RAISE = 2'd1;
    localparam logic [1:0] MOTION_LOWER = 2'd2;
    localparam logic [1:0] MOTION_CAP   = 2'd3;

    localparam logic       REQ_SAMPLE = 1'b0;
    localparam logic       REQ_TICK   = 1'b1;

    localparam logic [1:0] GEAR_SMALL = 2'd0;
    localparam logic [1:0] GEAR_LARGE = 2'd1;

    localparam logic [15:0] LARGE_CAP_DELAY = 16'd60;
    localparam logic [1:0]  IDLE_LIMIT      = 2'd3;

endpackage

FILE: rtl/core/tap_changer_auto_decision.sv
// Tap changer auto decision: voltage raise/lower and capacity change decision.
// Depends on tcad_pkg.
// Sample item: after accept it runs ST_VOLT, then per phase a square (ST_SQA, ST_SQB)
// and a 16-step bit-serial square root (three phases), then an 8-step radix-4
// ratio multiply, ST_CAP and ST_OUT. Next item is taken once the block is idle again.
// Tick item: ST_TICK then ST_OUT; both kinds wait in ST_OUT while the result stalls.
// rst_n (async, active low) clears control state and loads register defaults.
module tap_changer_auto_decision
    import tcad_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  in_item_t             item_data,
    output logic                 result_valid,
    input  logic                 result_stall,
    output out_item_t            result_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_TICK = 4'd1;
    localparam logic [3:0] ST_VOLT = 4'd2;
    localparam logic [3:0] ST_SQA  = 4'd3;
    localparam logic [3:0] ST_SQB  = 4'd4;
    localparam logic [3:0] ST_ROOT = 4'd5;
    localparam logic [3:0] ST_MUL3 = 4'd6;
    localparam logic [3:0] ST_MUL  = 4'd7;
    localparam logic [3:0] ST_CAP  = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // configuration
    logic [15:0] lower_thr_reg, raise_thr_reg, lock_low_reg, lock_high_reg;
    logic [33:0] cap_thr_reg;
    logic [15:0] cur_ratio_reg, volt_delay_reg, cap_delay_reg;

    // control state
    logic [3:0]  state_reg, state_next;
    logic        raise_flag_reg, raise_flag_next;
    logic        lower_flag_reg, lower_flag_next;
    logic        cap_flag_reg, cap_flag_next;
    logic [15:0] raise_cnt_reg, raise_cnt_next;
    logic [15:0] lower_cnt_reg, lower_cnt_next;
    logic [15:0] cap_cnt_reg, cap_cnt_next;
    logic [1:0]  volt_idle_reg, volt_idle_next;
    logic [1:0]  cap_idle_reg, cap_idle_next;
    logic [1:0]  motion_reg, motion_next;
    logic [1:0]  phase_reg, phase_next;
    logic [3:0]  step_reg, step_next;
    logic        result_valid_reg, result_valid_next;

    // datapath
    in_item_t    item_reg;
    logic [31:0] rad_reg, rad_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] root_reg, root_next;
    logic [17:0] mag_sum_reg, mag_sum_next;
    logic [19:0] mag3_reg, mag3_next;
    logic [15:0] ratio_sh_reg, ratio_sh_next;
    logic [33:0] prod_reg, prod_next;
    out_item_t   result_reg, result_next;

    logic        accept;
    logic        out_free;
    logic [15:0] p_raw, q_raw, p_mag, q_mag, sq_in;
    logic [31:0] sq;
    logic [17:0] volt_sum, lower_lim, raise_lim;
    logic [15:0] vmin, vmax;
    logic [18:0] rem_shift, trial;
    logic        root_bit;
    logic [15:0] root_new;
    logic [19:0] addend;
    logic [15:0] cap_dly;

    assign item_stall   = (state_reg != ST_IDLE);
    assign accept       = item_valid && !item_stall;
    assign out_free     = !result_valid_reg || !result_stall;
    assign result_valid = result_valid_reg;
    assign result_data  = result_reg;

    // phase operand select and magnitudes
    always_comb
    begin
        unique case (phase_reg)
            2'd0:
            begin
                p_raw = item_reg.real_a;
                q_raw = item_reg.reactive_a;
            end
            2'd1:
            begin
                p_raw = item_reg.real_b;
                q_raw = item_reg.reactive_b;
            end
            default:
            begin
                p_raw = item_reg.real_c;
                q_raw = item_reg.reactive_c;
            end
        endcase
    end

    assign p_mag = p_raw[15] ? (16'd0 - p_raw) : p_raw;
    assign q_mag = q_raw[15] ? (16'd0 - q_raw) : q_raw;
    assign sq_in = (state_reg == ST_SQA) ? p_mag : q_mag;
    assign sq    = {16'd0, sq_in} * {16'd0, sq_in};

    // voltage compare, sum against 3x threshold
    assign volt_sum  = {2'd0, item_reg.volt_a} + {2'd0, item_reg.volt_b}
                     + {2'd0, item_reg.volt_c};
    assign lower_lim = {2'd0, lower_thr_reg} + {1'b0, lower_thr_reg, 1'b0};
    assign raise_lim = {2'd0, raise_thr_reg} + {1'b0, raise_thr_reg, 1'b0};

    always_comb
    begin
        vmin = item_reg.volt_a;
        vmax = item_reg.volt_a;
        if (item_reg.volt_b < vmin) vmin = item_reg.volt_b;
        if (item_reg.volt_c < vmin) vmin = item_reg.volt_c;
        if (item_reg.volt_b > vmax) vmax = item_reg.volt_b;
        if (item_reg.volt_c > vmax) vmax = item_reg.volt_c;
    end

    // one root bit per cycle, radicand shifted in two bits at a time
    assign rem_shift = {rem_reg, rad_reg[31:30]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign root_bit  = (rem_shift >= trial);
    assign root_new  = {root_reg[14:0], root_bit};

    always_comb
    begin
        unique case (ratio_sh_reg[15:14])
            2'd0:    addend = 20'd0;
            2'd1:    addend = {2'd0, mag_sum_reg};
            2'd2:    addend = {1'b0, mag_sum_reg, 1'b0};
            default: addend = mag3_reg;
        endcase
    end

    assign cap_dly = item_reg.large_capacity_now ? LARGE_CAP_DELAY : cap_delay_reg;

    always_comb
    begin
        state_next        = state_reg;
        raise_flag_next   = raise_flag_reg;
        lower_flag_next   = lower_flag_reg;
        cap_flag_next     = cap_flag_reg;
        raise_cnt_next    = raise_cnt_reg;
        lower_cnt_next    = lower_cnt_reg;
        cap_cnt_next      = cap_cnt_reg;
        volt_idle_next    = volt_idle_reg;
        cap_idle_next     = cap_idle_reg;
        motion_next       = motion_reg;
        phase_next        = phase_reg;
        step_next         = step_reg;
        result_valid_next = result_valid_reg && result_stall;
        rad_next          = rad_reg;
        rem_next          = rem_reg;
        root_next         = root_reg;
        mag_sum_next      = mag_sum_reg;
        mag3_next         = mag3_reg;
        ratio_sh_next     = ratio_sh_reg;
        prod_next         = prod_reg;
        result_next       = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item_data.req_type == REQ_TICK) ? ST_TICK : ST_VOLT;
                end
            end
            ST_TICK:
            begin
                // voltage part
                if (raise_flag_reg)
                begin
                    if (raise_cnt_reg < volt_delay_reg)
                        raise_cnt_next = raise_cnt_reg + 16'd1;
                    else
                        motion_next = MOTION_RAISE;
                end
                else if (lower_flag_reg)
                begin
                    if (lower_cnt_reg < volt_delay_reg)
                        lower_cnt_next = lower_cnt_reg + 16'd1;
                    else
                        motion_next = MOTION_LOWER;
                end
                else if (volt_idle_reg < IDLE_LIMIT)
                begin
                    volt_idle_next = volt_idle_reg + 2'd1;
                end
                else
                begin
                    motion_next    = MOTION_NONE;
                    raise_cnt_next = 16'd0;
                    lower_cnt_next = 16'd0;
                    volt_idle_next = 2'd0;
                end
                // capacity part, overrides the voltage motion
                if (cap_flag_reg)
                begin
                    if (cap_cnt_reg < cap_dly)
                        cap_cnt_next = cap_cnt_reg + 16'd1;
                    else
                        motion_next = MOTION_CAP;
                end
                else if (cap_idle_reg < IDLE_LIMIT)
                begin
                    cap_idle_next = cap_idle_reg + 2'd1;
                end
                else
                begin
                    motion_next   = MOTION_NONE;
                    cap_cnt_next  = 16'd0;
                    cap_idle_next = 2'd0;
                end
                state_next = ST_OUT;
            end
            ST_VOLT:
            begin
                if ((volt_sum > lower_lim) && (vmin > lock_low_reg))
                begin
                    lower_flag_next = 1'b1;
                    raise_flag_next = 1'b0;
                end
                else if ((volt_sum < raise_lim) && (vmax < lock_high_reg))
                begin
                    lower_flag_next = 1'b0;
                    raise_flag_next = 1'b1;
                end
                else
                begin
                    lower_flag_next = 1'b0;
                    raise_flag_next = 1'b0;
                end
                phase_next   = 2'd0;
                mag_sum_next = 18'd0;
                state_next   = ST_SQA;
            end
            ST_SQA:
            begin
                rad_next   = sq;
                state_next = ST_SQB;
            end
            ST_SQB:
            begin
                rad_next   = rad_reg + sq;
                rem_next   = 17'd0;
                root_next  = 16'd0;
                step_next  = 4'd0;
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                rem_next  = root_bit ? 17'(rem_shift - trial) : rem_shift[16:0];
                root_next = root_new;
                rad_next  = {rad_reg[29:0], 2'b00};
                step_next = step_reg + 4'd1;
                if (step_reg == 4'd15)
                begin
                    mag_sum_next = mag_sum_reg + {2'd0, root_new};
                    if (phase_reg == 2'd2)
                    begin
                        state_next = ST_MUL3;
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                        state_next = ST_SQA;
                    end
                end
            end
            ST_MUL3:
            begin
                mag3_next     = {2'd0, mag_sum_reg} + {1'b0, mag_sum_reg, 1'b0};
                ratio_sh_next = cur_ratio_reg;
                prod_next     = 34'd0;
                step_next     = 4'd0;
                state_next    = ST_MUL;
            end
            ST_MUL:
            begin
                // radix-4, most significant digit of the ratio first
                prod_next     = {prod_reg[31:0], 2'b00} + {14'd0, addend};
                ratio_sh_next = {ratio_sh_reg[13:0], 2'b00};
                step_next     = step_reg + 4'd1;
                if (step_reg[2:0] == 3'd7)
                    state_next = ST_CAP;
            end
            ST_CAP:
            begin
                if (item_reg.gear_setting == GEAR_SMALL)
                    cap_flag_next = (prod_reg < cap_thr_reg);
                else if (item_reg.gear_setting == GEAR_LARGE)
                    cap_flag_next = (prod_reg > cap_thr_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    result_next.motion           = motion_reg;
                    result_next.raise_request    = raise_flag_reg;
                    result_next.lower_request    = lower_flag_reg;
                    result_next.capacity_request = cap_flag_reg;
                    result_valid_next            = 1'b1;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            raise_flag_reg   <= 1'b0;
            lower_flag_reg   <= 1'b0;
            cap_flag_reg     <= 1'b0;
            raise_cnt_reg    <= 16'd0;
            lower_cnt_reg    <= 16'd0;
            cap_cnt_reg      <= 16'd0;
            volt_idle_reg    <= 2'd0;
            cap_idle_reg     <= 2'd0;
            motion_reg       <= MOTION_NONE;
            phase_reg        <= 2'd0;
            step_reg         <= 4'd0;
            result_valid_reg <= 1'b0;
            lower_thr_reg    <= 16'hFFFF;
            raise_thr_reg    <= 16'd0;
            lock_low_reg     <= 16'd0;
            lock_high_reg    <= 16'hFFFF;
            cap_thr_reg      <= 34'd0;
            cur_ratio_reg    <= 16'd1;
            volt_delay_reg   <= 16'd0;
            cap_delay_reg    <= 16'd0;
        end
        else
        begin
            state_reg        <= state_next;
            raise_flag_reg   <= raise_flag_next;
            lower_flag_reg   <= lower_flag_next;
            cap_flag_reg     <= cap_flag_next;
            raise_cnt_reg    <= raise_cnt_next;
            lower_cnt_reg    <= lower_cnt_next;
            cap_cnt_reg      <= cap_cnt_next;
            volt_idle_reg    <= volt_idle_next;
            cap_idle_reg     <= cap_idle_next;
            motion_reg       <= motion_next;
            phase_reg        <= phase_next;
            step_reg         <= step_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOWER_THR:  lower_thr_reg  <= cfg_data[15:0];
                    REG_RAISE_THR:  raise_thr_reg  <= cfg_data[15:0];
                    REG_LOCK_LOW:   lock_low_reg   <= cfg_data[15:0];
                    REG_LOCK_HIGH:  lock_high_reg  <= cfg_data[15:0];
                    REG_CAP_THR:    cap_thr_reg    <= cfg_data;
                    REG_CUR_RATIO:  cur_ratio_reg  <= cfg_data[15:0];
                    REG_VOLT_DELAY: volt_delay_reg <= cfg_data[15:0];
                    REG_CAP_DELAY:  cap_delay_reg  <= cfg_data[15:0];
                    default:        cap_delay_reg  <= cap_delay_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_data;
        rad_reg      <= rad_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        mag_sum_reg  <= mag_sum_next;
        mag3_reg     <= mag3_next;
        ratio_sh_reg <= ratio_sh_next;
        prod_reg     <= prod_next;
        result_reg   <= result_next;
    end

endmodule

FILE: tb/tb_tap_changer_auto_decision.sv
// Self-checking testbench for tap_changer_auto_decision: queued items, random
// handshake gaps, a built-in decision predictor and an in-order result check.
// Depends on tcad_pkg and the tap_changer_auto_decision RTL.
`timescale 1ns / 1ps

module tb_tap_changer_auto_decision;
    import tcad_pkg::*;

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam logic [1:0] GEAR_OTHER_A = 2'd2;
    localparam logic [1:0] GEAR_OTHER_B = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             item_valid = 1'b0;
    logic             item_stall;
    in_item_t         item_data = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    out_item_t        result_data;
    logic             cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    tap_changer_auto_decision i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item_data    (item_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register mirror, reset values
    logic [15:0] lower_thr_r   = 16'hFFFF;
    logic [15:0] raise_thr_r   = 16'd0;
    logic [15:0] lock_low_r    = 16'd0;
    logic [15:0] lock_high_r   = 16'hFFFF;
    logic [33:0] cap_thr_r     = 34'd0;
    logic [15:0] cur_ratio_r   = 16'd1;
    logic [15:0] volt_delay_r  = 16'd0;
    logic [15:0] cap_delay_r   = 16'd0;

    // decision state
    logic        want_raise    = 1'b0;
    logic        want_lower    = 1'b0;
    logic        want_capacity = 1'b0;
    logic [15:0] raise_ticks   = '0;
    logic [15:0] lower_ticks   = '0;
    logic [15:0] cap_ticks     = '0;
    logic [1:0]  volt_quiet    = '0;
    logic [1:0]  cap_quiet     = '0;
    logic [1:0]  motion_now    = MOTION_NONE;

    in_item_t    pending_items[$];
    out_item_t   expected_decisions[$];
    int unsigned items_queued = 0;
    int unsigned items_sent = 0;
    int unsigned fail_count = 0;

    int unsigned send_gap_max = 9;
    int unsigned recv_stall_max = 9;
    int unsigned send_wait = 0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    logic        long_hold_req = 1'b0;
    logic        item_taken = 1'b0;
    logic        result_taken = 1'b0;
    int unsigned quiet_cycles = 0;

    function automatic logic [15:0] phase_magnitude(input logic signed [15:0] p,
                                                    input logic signed [15:0] q);
        longint sq;
        longint root;
        longint trial;
        sq = longint'(p) * longint'(p) + longint'(q) * longint'(q);
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sq)
                root = trial;
        end
        return root[15:0];
    endfunction

    // Advances the decision state by one item and records the result it gives.
    task automatic decide_step(input in_item_t it);
        int unsigned     vsum;
        int unsigned     vmin;
        int unsigned     vmax;
        longint unsigned power;
        logic [15:0]     cap_limit;
        out_item_t       res;
        if (it.req_type == REQ_SAMPLE)
        begin
            vsum = it.volt_a + it.volt_b + it.volt_c;
            vmin = it.volt_a;
            vmax = it.volt_a;
            if (it.volt_b < vmin) vmin = it.volt_b;
            if (it.volt_c < vmin) vmin = it.volt_c;
            if (it.volt_b > vmax) vmax = it.volt_b;
            if (it.volt_c > vmax) vmax = it.volt_c;
            if (vsum > 3 * lower_thr_r && vmin > lock_low_r)
            begin
                want_lower = 1'b1;
                want_raise = 1'b0;
            end
            else if (vsum < 3 * raise_thr_r && vmax < lock_high_r)
            begin
                want_lower = 1'b0;
                want_raise = 1'b1;
            end
            else
            begin
                want_lower = 1'b0;
                want_raise = 1'b0;
            end
            power = longint'(phase_magnitude(it.real_a, it.reactive_a))
                  + longint'(phase_magnitude(it.real_b, it.reactive_b))
                  + longint'(phase_magnitude(it.real_c, it.reactive_c));
            power = power * cur_ratio_r;
            if (it.gear_setting == GEAR_SMALL)
                want_capacity = power < cap_thr_r;
            else if (it.gear_setting == GEAR_LARGE)
                want_capacity = power > cap_thr_r;
        end
        else
        begin
            cap_limit = it.large_capacity_now ? LARGE_CAP_DELAY : cap_delay_r;
            if (want_raise)
            begin
                if (raise_ticks < volt_delay_r)
                    raise_ticks++;
                else
                    motion_now = MOTION_RAISE;
            end
            else if (want_lower)
            begin
                if (lower_ticks < volt_delay_r)
                    lower_ticks++;
                else
                    motion_now = MOTION_LOWER;
            end
            else if (volt_quiet < IDLE_LIMIT)
                volt_quiet++;
            else
            begin
                motion_now = MOTION_NONE;
                raise_ticks = '0;
                lower_ticks = '0;
                volt_quiet = '0;
            end
            // capacity part runs second, so its motion code wins
            if (want_capacity)
            begin
                if (cap_ticks < cap_limit)
                    cap_ticks++;
                else
                    motion_now = MOTION_CAP;
            end
            else if (cap_quiet < IDLE_LIMIT)
                cap_quiet++;
            else
            begin
                motion_now = MOTION_NONE;
                cap_ticks = '0;
                cap_quiet = '0;
            end
        end
        res.motion = motion_now;
        res.raise_request = want_raise;
        res.lower_request = want_lower;
        res.capacity_request = want_capacity;
        expected_decisions.push_back(res);
    endtask

    function automatic in_item_t random_bits();
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        return in_item_t'(raw[$bits(in_item_t)-1:0]);
    endfunction

    function automatic in_item_t sample_item(input logic [15:0] va, input logic [15:0] vb,
                                             input logic [15:0] vc,
                                             input logic signed [15:0] p,
                                             input logic signed [15:0] q,
                                             input logic [1:0] gear);
        in_item_t it;
        it = random_bits();
        it.req_type = REQ_SAMPLE;
        it.volt_a = va;
        it.volt_b = vb;
        it.volt_c = vc;
        it.real_a = p;
        it.reactive_a = q;
        it.real_b = q;
        it.reactive_b = p;
        it.real_c = p;
        it.reactive_c = q;
        it.gear_setting = gear;
        return it;
    endfunction

    function automatic in_item_t tick_item(input logic big_cap);
        in_item_t it;
        it = random_bits();
        it.req_type = REQ_TICK;
        it.large_capacity_now = big_cap;
        return it;
    endfunction

    function automatic logic [15:0] volt_near(input logic [15:0] mark);
        int v;
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        v = int'(mark) + int'($urandom_range(0, 40)) - 20;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return 16'(v);
    endfunction

    // Voltages mostly clustered around one of the live thresholds so the flags move.
    function automatic in_item_t random_sample();
        in_item_t    it;
        logic [15:0] mark;
        logic [2:0]  g;
        it = random_bits();
        it.req_type = REQ_SAMPLE;
        case ($urandom_range(0, 4))
            0:       mark = lower_thr_r;
            1:       mark = raise_thr_r;
            2:       mark = lock_low_r;
            3:       mark = lock_high_r;
            default: mark = 16'($urandom);
        endcase
        it.volt_a = volt_near(mark);
        it.volt_b = volt_near(mark);
        it.volt_c = volt_near(mark);
        if ($urandom_range(0, 3) == 0)
        begin
            it.real_a     = 16'($urandom_range(0, 400)) - 16'd200;
            it.reactive_a = 16'($urandom_range(0, 400)) - 16'd200;
            it.real_b     = 16'($urandom_range(0, 400)) - 16'd200;
            it.reactive_b = 16'($urandom_range(0, 400)) - 16'd200;
            it.real_c     = 16'($urandom_range(0, 400)) - 16'd200;
            it.reactive_c = 16'($urandom_range(0, 400)) - 16'd200;
        end
        g = 3'($urandom_range(0, 7));
        it.gear_setting = (g < 3'd6) ? {1'b0, g[0]} : g[1:0];
        return it;
    endfunction

    task automatic offer(input in_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // A sample followed by a run of ticks; now and then a fully random item.
    task automatic queue_random(input int n);
        int   left;
        int   run;
        logic big_cap;
        left = n;
        while (left > 0)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                offer(random_bits());
                left--;
            end
            else
            begin
                offer(random_sample());
                left--;
                if ($urandom_range(0, 9) == 0)
                begin
                    run = $urandom_range(55, 70);
                    big_cap = 1'($urandom_range(0, 1));
                end
                else
                begin
                    run = $urandom_range(0, 8);
                    big_cap = ($urandom_range(0, 9) == 0);
                end
                for (int k = 0; k < run && left > 0; k++)
                begin
                    offer(tick_item(big_cap ^ ($urandom_range(0, 7) == 0)));
                    left--;
                end
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LOWER_THR:  lower_thr_r = value[15:0];
            REG_RAISE_THR:  raise_thr_r = value[15:0];
            REG_LOCK_LOW:   lock_low_r = value[15:0];
            REG_LOCK_HIGH:  lock_high_r = value[15:0];
            REG_CAP_THR:    cap_thr_r = value[33:0];
            REG_CUR_RATIO:  cur_ratio_r = value[15:0];
            REG_VOLT_DELAY: volt_delay_r = value[15:0];
            REG_CAP_DELAY:  cap_delay_r = value[15:0];
            default: ;
        endcase
    endtask

    task automatic configure(input int lower, input int raise, input int lock_low,
                             input int lock_high, input longint unsigned cap_thr,
                             input int ratio, input int vdelay, input int cdelay);
        write_reg(REG_LOWER_THR, CFG_W'(lower));
        write_reg(REG_RAISE_THR, CFG_W'(raise));
        write_reg(REG_LOCK_LOW, CFG_W'(lock_low));
        write_reg(REG_LOCK_HIGH, CFG_W'(lock_high));
        write_reg(REG_CAP_THR, CFG_W'(cap_thr));
        write_reg(REG_CUR_RATIO, CFG_W'(ratio));
        write_reg(REG_VOLT_DELAY, CFG_W'(vdelay));
        write_reg(REG_CAP_DELAY, CFG_W'(cdelay));
    endtask

    task automatic drain(input int settle);
        wait (items_sent == items_queued && expected_decisions.size() == 0);
        repeat (settle) @(posedge clk);
    endtask

    // item sender
    always @(negedge clk)
    begin
        if (rst_n && (!item_valid || item_taken))
        begin
            if (send_wait > 0)
            begin
                send_wait--;
                item_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                item_data <= pending_items.pop_front();
                item_valid <= 1'b1;
                send_wait = $urandom_range(0, send_gap_max);
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        item_taken <= rst_n && item_valid && !item_stall;
        if (rst_n && item_valid && !item_stall)
        begin
            decide_step(item_data);
            items_sent++;
        end
    end

    // result receiver: per-item stall plus one long hold on request
    always @(negedge clk)
    begin
        if (long_hold_req)
        begin
            hold_left = HOLD_CYCLES;
            long_hold_req = 1'b0;
        end
        if (result_taken)
            recv_wait = $urandom_range(0, recv_stall_max);
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (recv_wait > 0)
        begin
            recv_wait--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        result_taken <= rst_n && result_valid && !result_stall;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_decisions.size() == 0)
            begin
                $error("decision item with none expected: %h", result_data);
                fail_count++;
            end
            else
            begin
                want = expected_decisions.pop_front();
                if (result_data.motion !== want.motion)
                begin
                    $error("motion: expected %0d, got %0d", want.motion, result_data.motion);
                    fail_count++;
                end
                if (result_data.raise_request !== want.raise_request)
                begin
                    $error("raise_request: expected %0d, got %0d",
                           want.raise_request, result_data.raise_request);
                    fail_count++;
                end
                if (result_data.lower_request !== want.lower_request)
                begin
                    $error("lower_request: expected %0d, got %0d",
                           want.lower_request, result_data.lower_request);
                    fail_count++;
                end
                if (result_data.capacity_request !== want.capacity_request)
                begin
                    $error("capacity_request: expected %0d, got %0d",
                           want.capacity_request, result_data.capacity_request);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tap_changer_auto_decision test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int              rv;
        int              lv;
        int              ratio;
        longint unsigned cap;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: no voltage request can form, capacity compares against 0
        offer(sample_item(16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd32768, -16'sd32768, GEAR_LARGE));
        offer(tick_item(1'b0));
        drain(8);

        configure(1000, 500, 100, 60000, 100000, 2, 1, 2);
        offer(sample_item(16'hFFFF, 16'hFFFF, 16'hFFFF, -16'sd32768, -16'sd32768, GEAR_LARGE));
        offer(tick_item(1'b0));
        offer(tick_item(1'b0));
        offer(tick_item(1'b0));
        offer(sample_item(16'd0, 16'd0, 16'd0, 16'sd0, 16'sd0, GEAR_SMALL));
        offer(tick_item(1'b1));
        offer(tick_item(1'b1));
        // lower blocked by the low lock; gear outside 0/1 keeps the capacity flag
        offer(sample_item(16'hFFFF, 16'hFFFF, 16'd50, 16'sd32767, -16'sd32768, GEAR_OTHER_A));
        // sums exactly at three times a threshold
        offer(sample_item(16'd1000, 16'd1000, 16'd1000, 16'sd0, 16'sd32767, GEAR_OTHER_B));
        offer(sample_item(16'd1001, 16'd1000, 16'd1000, 16'sd10, -16'sd10, GEAR_SMALL));
        offer(sample_item(16'd499, 16'd500, 16'd500, 16'sd0, 16'sd0, GEAR_LARGE));
        offer(sample_item(16'd500, 16'd500, 16'd500, 16'sd0, 16'sd0, GEAR_LARGE));
        offer(sample_item(16'd100, 16'd5000, 16'd5000, 16'sd0, 16'sd0, GEAR_LARGE));
        // idle ticks run out and clear motion and counters
        repeat (5) offer(tick_item(1'b0));
        offer(sample_item(16'd400, 16'd400, 16'd600, 16'sd32767, 16'sd32767, GEAR_SMALL));
        repeat (3) offer(tick_item(1'b0));
        drain(8);

        for (int phase = 0; phase < 8; phase++)
        begin
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            recv_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 9;
            if (phase == 0)
                configure(65535, 65535, 65535, 65535, 64'h3_FFFF_FFFF, 65535, 65535, 65535);
            else if (phase == 1)
                configure(0, 0, 0, 0, 0, 1, 0, 0);
            else
            begin
                rv = $urandom_range(0, 60000);
                lv = rv + $urandom_range(0, 4000);
                ratio = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                    : $urandom_range(1, 4);
                cap = longint'(ratio) * $urandom_range(20000, 120000);
                configure(lv, rv, (lv > 3000) ? lv - $urandom_range(0, 3000) : 0,
                          rv + $urandom_range(0, 3000), cap, ratio,
                          $urandom_range(0, 6), $urandom_range(0, 6));
            end
            if (phase == 4)
            begin
                // receiver holds off while the sender keeps pushing
                send_gap_max = 0;
                long_hold_req = 1'b1;
            end
            queue_random(100);
            drain(8);
        end

        repeat (80) @(posedge clk);
        if (fail_count == 0)
            $display("tap_changer_auto_decision test passed");
        else
            $display("tap_changer_auto_decision test failed");
        $finish;
    end

endmodule
